FILE: sv/multi_term_substring_filter_top_defines.svh
// ----------------------------------------------------------------------------
// multi-term substring filter assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_TERM_SUBSTRING_FILTER_TOP_DEFINES_SVH
`define MULTI_TERM_SUBSTRING_FILTER_TOP_DEFINES_SVH

// same-cycle implication
`define MTSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtsf check failed");

// next-cycle implication
`define MTSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtsf check failed");

`endif

FILE: sv/mtsf_pkg.sv
// ----------------------------------------------------------------------------
// mtsf_pkg
// shared sizes, types and function codes of the multi-term substring filter
// ----------------------------------------------------------------------------
package mtsf_pkg;

  // query limits
  localparam int MaxTerms   = 8;
  localparam int MaxTermLen = 32;

  // derived widths
  localparam int LenW     = $clog2(MaxTermLen + 1);
  localparam int CountW   = $clog2(MaxTerms + 1);
  localparam int TermIdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int PosW     = (MaxTermLen > 1) ? $clog2(MaxTermLen) : 1;

  localparam int ByteW   = 8;
  localparam int IndexW  = 16;

  localparam logic [ByteW-1:0]      SpaceChar = 8'h20;
  localparam logic [MaxTermLen-1:0] VecOne    = MaxTermLen'(1);

  // item function codes
  typedef enum logic [1:0] {
    FuncClear  = 2'd0,
    FuncAppend = 2'd1,
    FuncRecord = 2'd2,
    FuncEnd    = 2'd3
  } func_e;

  // one item as it leaves the input register
  typedef struct packed {
    logic             valid;
    func_e            func;
    logic [ByteW-1:0] data;
  } op_t;

  typedef logic [MaxTerms-1:0][MaxTermLen-1:0][ByteW-1:0] chars_t;
  typedef logic [MaxTerms-1:0][LenW-1:0]                  lens_t;

endpackage

FILE: sv/mtsf_query.sv
// ----------------------------------------------------------------------------
// mtsf_query
// query store: splits query bytes into terms, keeps characters and lengths
// ----------------------------------------------------------------------------
module mtsf_query (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtsf_pkg::op_t   op_i,
  output mtsf_pkg::chars_t chars_o,
  output mtsf_pkg::lens_t lens_o,
  output logic            overflow_o
);

  mtsf_pkg::chars_t chars_q;
  mtsf_pkg::lens_t  lens_q, lens_d;
  logic [mtsf_pkg::CountW-1:0]   count_q, count_d;
  logic                          ovf_q, ovf_d;
  logic                          drop_q, drop_d;
  logic [mtsf_pkg::TermIdxW-1:0] cur;
  logic [mtsf_pkg::LenW-1:0]     cur_len;
  logic                          wr_en;
  logic [mtsf_pkg::PosW-1:0]     wr_pos;

  assign cur      = mtsf_pkg::TermIdxW'(count_q - mtsf_pkg::CountW'(1));
  assign cur_len  = lens_q[cur];
  assign wr_pos   = cur_len[mtsf_pkg::PosW-1:0];

  // term splitting and overflow tracking
  always_comb begin
    lens_d  = lens_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    drop_d  = drop_q;
    wr_en   = 1'b0;
    if (op_i.valid) begin
      case (op_i.func)
        mtsf_pkg::FuncClear: begin
          lens_d  = '0;
          count_d = mtsf_pkg::CountW'(1);
          ovf_d   = 1'b0;
          drop_d  = 1'b0;
        end
        mtsf_pkg::FuncAppend: begin
          if (op_i.data == mtsf_pkg::SpaceChar) begin
            if (drop_q || (count_q >= mtsf_pkg::CountW'(mtsf_pkg::MaxTerms))) begin
              drop_d = 1'b1;
              ovf_d  = 1'b1;
            end else begin
              count_d = count_q + mtsf_pkg::CountW'(1);
            end
          end else if (drop_q || (cur_len >= mtsf_pkg::LenW'(mtsf_pkg::MaxTermLen))) begin
            ovf_d = 1'b1;
          end else begin
            wr_en        = 1'b1;
            lens_d[cur]  = cur_len + mtsf_pkg::LenW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lens_q  <= '0;
      count_q <= mtsf_pkg::CountW'(1);
      ovf_q   <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      lens_q  <= lens_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      drop_q  <= drop_d;
    end
  end

  // term characters, written one byte at a time
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      chars_q[cur][wr_pos] <= op_i.data;
    end
  end

  assign chars_o    = chars_q;
  assign lens_o     = lens_q;
  assign overflow_o = ovf_q;

endmodule

FILE: sv/mtsf_match.sv
// ----------------------------------------------------------------------------
// mtsf_match
// shift-and matcher: one partial-match vector and found flag per term,
// all terms advance together on each record byte
// ----------------------------------------------------------------------------
module mtsf_match (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtsf_pkg::op_t    op_i,
  input  mtsf_pkg::chars_t chars_i,
  input  mtsf_pkg::lens_t  lens_i,
  output logic             all_found_o
);

  logic [mtsf_pkg::MaxTerms-1:0][mtsf_pkg::MaxTermLen-1:0] pm_q, pm_d;
  logic [mtsf_pkg::MaxTerms-1:0] seen_q, seen_d;
  logic [mtsf_pkg::MaxTerms-1:0] term_ok;
  logic [mtsf_pkg::MaxTermLen-1:0] cmask, keep, last, step;

  // per-term vector update
  always_comb begin
    pm_d   = pm_q;
    seen_d = seen_q;
    cmask  = '0;
    keep   = '0;
    last   = '0;
    step   = '0;
    for (int t = 0; t < mtsf_pkg::MaxTerms; t++) begin
      for (int j = 0; j < mtsf_pkg::MaxTermLen; j++) begin
        cmask[j] = (chars_i[t][j] == op_i.data);
        keep[j]  = (mtsf_pkg::LenW'(j) < lens_i[t]);
        last[j]  = (mtsf_pkg::LenW'(j + 1) == lens_i[t]);
      end
      step = ((pm_q[t] << 1) | mtsf_pkg::VecOne) & cmask & keep;
      if (op_i.valid && (op_i.func == mtsf_pkg::FuncRecord) &&
          (lens_i[t] != '0)) begin
        pm_d[t] = step;
        if (|(step & last)) begin
          seen_d[t] = 1'b1;
        end
      end
    end
    // any other item drops partial matches
    if (op_i.valid && (op_i.func != mtsf_pkg::FuncRecord)) begin
      pm_d   = '0;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q   <= '0;
      seen_q <= '0;
    end else begin
      pm_q   <= pm_d;
      seen_q <= seen_d;
    end
  end

  // empty terms always match
  always_comb begin
    for (int t = 0; t < mtsf_pkg::MaxTerms; t++) begin
      term_ok[t] = seen_q[t] || (lens_i[t] == '0);
    end
  end

  assign all_found_o = &term_ok;

endmodule

FILE: sv/multi_term_substring_filter_top.sv
// ----------------------------------------------------------------------------
// multi_term_substring_filter_top
// multi-term substring AND filter: query loading, parallel shift-and match
// of every term against a record stream, one result per end of record
//
//   channel  | direction | tdata                            | tuser
//   s_axis   | in        | [7:0] data_byte                  | [1:0] func
//   m_axis   | out       | [15:0] record_index,             | -
//            |           | [16] all_terms_found,            |
//            |           | [17] query_overflow              |
//
// one item per cycle sustained while no end item waits on a stalled result
// register; an item is worked between the input register and the result
// register, as it leaves the input register; end-of-record results are loaded
// at the edge where the item leaves the input register; only a stalled result
// register holds an end-of-record item back, and then the input stalls with it
// reset gives a single empty query term and record index zero
// ----------------------------------------------------------------------------
module multi_term_substring_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] record_index, [16] all_terms_found,
                                      // [17] query_overflow, [23:18] zero
);

  logic                              in_valid_q;
  mtsf_pkg::func_e                   in_func_q;
  logic [mtsf_pkg::ByteW-1:0]        in_data_q;
  logic                              advance;
  logic                              out_load;
  logic                              out_valid_q;
  logic [mtsf_pkg::IndexW-1:0]       out_index_q;
  logic                              out_all_q;
  logic                              out_ovf_q;
  logic [mtsf_pkg::IndexW-1:0]       rec_cnt_q;
  mtsf_pkg::op_t                     op;
  mtsf_pkg::chars_t                  chars;
  mtsf_pkg::lens_t                   lens;
  logic                              overflow;
  logic                              all_found;

  // input register moves on unless an end item waits on a full result register
  assign advance  = in_valid_q &&
                    ((in_func_q != mtsf_pkg::FuncEnd) || !out_valid_q || m_axis_tready);
  assign out_load = advance && (in_func_q == mtsf_pkg::FuncEnd);
  assign s_axis_tready = !in_valid_q || advance;

  assign op = '{valid: advance, func: in_func_q, data: in_data_q};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      rec_cnt_q   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        rec_cnt_q   <= rec_cnt_q + mtsf_pkg::IndexW'(1);
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= mtsf_pkg::func_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_index_q <= rec_cnt_q;
      out_all_q   <= all_found;
      out_ovf_q   <= overflow;
    end
  end

  mtsf_query u_query (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .chars_o    (chars),
    .lens_o     (lens),
    .overflow_o (overflow)
  );

  mtsf_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .chars_i     (chars),
    .lens_i      (lens),
    .all_found_o (all_found)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_ovf_q, out_all_q, out_index_q};

endmodule

FILE: sv/mtsf_checker.sv
// ----------------------------------------------------------------------------
// mtsf_checker
// port-level checks of the multi-term substring filter
// ----------------------------------------------------------------------------
`include "multi_term_substring_filter_top_defines.svh"

module mtsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result stays offered
  `MTSF_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a stalled result keeps its payload
  `MTSF_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // back-to-back results carry consecutive record indices
  `MTSF_ASSERT_NOW(a_index_step,
    (m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && m_axis_tready),
    m_axis_tdata[15:0] == ($past(m_axis_tdata[15:0]) + 16'd1))

endmodule

bind multi_term_substring_filter_top mtsf_checker u_mtsf_checker (.*);

FILE: test/mtsf_checker.sv
// ----------------------------------------------------------------------------
// mtsf_scoreboard
// watches both stream channels of the multi-term substring filter, keeps its
// own copy of the query terms and match state, predicts every end-of-record
// result and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
module mtsf_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [15:0] record_index, [16] all_terms_found,
                                      // [17] query_overflow, [23:18] zero
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mtsf_pkg::IndexW-1:0] rec_index;
    logic                        all_found;
    logic                        overflow;
  } verdict_t;

  // query as the block should hold it
  logic [mtsf_pkg::ByteW-1:0]      term_text [mtsf_pkg::MaxTerms][mtsf_pkg::MaxTermLen];
  logic [mtsf_pkg::LenW-1:0]       term_len  [mtsf_pkg::MaxTerms];
  int                              term_total;
  logic                            query_ovf;
  logic                            dropping;

  // per-record match state
  logic [mtsf_pkg::MaxTermLen-1:0] shift_vec [mtsf_pkg::MaxTerms];
  logic                            term_hit  [mtsf_pkg::MaxTerms];
  logic [mtsf_pkg::IndexW-1:0]     record_idx;

  verdict_t                        verdict_q[$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count_o++;
  endtask

  task automatic clear_partials();
    for (int t = 0; t < mtsf_pkg::MaxTerms; t++) begin
      shift_vec[t] = '0;
      term_hit[t]  = 1'b0;
    end
  endtask

  task automatic clear_terms();
    for (int t = 0; t < mtsf_pkg::MaxTerms; t++) begin
      term_len[t] = '0;
    end
    term_total = 1;
    query_ovf  = 1'b0;
    dropping   = 1'b0;
    clear_partials();
  endtask

  // a space opens a new term; bytes past the limits are dropped
  task automatic add_query_byte(input logic [mtsf_pkg::ByteW-1:0] c);
    int cur;
    cur = term_total - 1;
    clear_partials();
    if (c == mtsf_pkg::SpaceChar) begin
      if (dropping || term_total >= mtsf_pkg::MaxTerms) begin
        dropping  = 1'b1;
        query_ovf = 1'b1;
      end else begin
        term_len[term_total] = '0;
        term_total++;
      end
    end else if (dropping || cur >= mtsf_pkg::MaxTerms ||
                 term_len[cur] >= mtsf_pkg::MaxTermLen) begin
      query_ovf = 1'b1;
    end else begin
      term_text[cur][term_len[cur]] = c;
      term_len[cur]++;
    end
  endtask

  // shift-and step of every non-empty term
  task automatic scan_record_byte(input logic [mtsf_pkg::ByteW-1:0] c);
    logic [mtsf_pkg::MaxTermLen-1:0] hits;
    for (int t = 0; t < mtsf_pkg::MaxTerms && t < term_total; t++) begin
      if (term_len[t] != '0) begin
        hits = '0;
        for (int j = 0; j < term_len[t]; j++) begin
          if (term_text[t][j] == c) hits[j] = 1'b1;
        end
        shift_vec[t] = ((shift_vec[t] << 1) | mtsf_pkg::VecOne) & hits;
        if (shift_vec[t][term_len[t] - 1]) term_hit[t] = 1'b1;
      end
    end
  endtask

  // empty terms always count as found
  task automatic close_record();
    verdict_t v;
    v.rec_index = record_idx;
    v.all_found = 1'b1;
    for (int t = 0; t < mtsf_pkg::MaxTerms; t++) begin
      if (t < term_total && term_len[t] != '0 && !term_hit[t]) v.all_found = 1'b0;
    end
    v.overflow = query_ovf;
    verdict_q.insert(verdict_q.size(), v);
    record_idx++;
    clear_partials();
  endtask

  task automatic compare_result(input logic [23:0] word);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("result with no record pending, tdata %h", word));
      return;
    end
    want = verdict_q.pop_front();
    if (word[15:0] !== want.rec_index) begin
      report_mismatch($sformatf("record_index %h, want %h", word[15:0], want.rec_index));
    end
    if (word[16] !== want.all_found) begin
      report_mismatch($sformatf("all_terms_found %b, want %b (record %0d)",
                                word[16], want.all_found, want.rec_index));
    end
    if (word[17] !== want.overflow) begin
      report_mismatch($sformatf("query_overflow %b, want %b (record %0d)",
                                word[17], want.overflow, want.rec_index));
    end
    if (word[23:18] !== '0) begin
      report_mismatch($sformatf("padding bits %b not zero", word[23:18]));
    end
  endtask

  // results are checked before the item of the same edge is applied
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_terms();
      record_idx = '0;
      verdict_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        case (mtsf_pkg::func_e'(s_axis_tuser))
          mtsf_pkg::FuncClear:  clear_terms();
          mtsf_pkg::FuncAppend: add_query_byte(s_axis_tdata);
          mtsf_pkg::FuncRecord: scan_record_byte(s_axis_tdata);
          mtsf_pkg::FuncEnd:    close_record();
          default: begin
          end
        endcase
      end
    end
    pending_o = verdict_q.size();
  end

endmodule

FILE: test/multi_term_substring_filter_top_tb.sv
// ----------------------------------------------------------------------------
// multi_term_substring_filter_top_tb
// drives query and record items into the filter with bursty input and a
// stalling receiver, including one long hold-off; the checker predicts and
// compares every end-of-record result and the verdict is given at the end
// ----------------------------------------------------------------------------
module multi_term_substring_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget  = 1750;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [15:0] record_index, [16] all_terms_found,
                               // [17] query_overflow, [23:18] zero

  int          mismatch_count;
  int          pending_results;
  int          sent_count;
  int          burst_left;
  int          idle_cycles;
  logic        s_taken;
  bit          hold_req;

  // term copies used to build records that hit
  logic [7:0]  pool_text [16][40];
  int          pool_len  [16];
  int          pool_n;

  multi_term_substring_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mtsf_scoreboard u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_results)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // input handshake seen at the edge, read back at the falling edge
  always @(posedge clk_i) begin
    s_taken <= s_axis_tvalid && s_axis_tready;
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // mostly a small alphabet so that terms do occur
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return 8'h61 + 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // one item, with a random gap whenever a burst runs out
  task automatic send_item(input mtsf_pkg::func_e f, input logic [7:0] d);
    int gap;
    int r;
    if (burst_left == 0) begin
      r = $urandom_range(0, 9);
      gap = (r < 3) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 30);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= d;
    do @(negedge clk_i); while (!s_taken);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_string(input mtsf_pkg::func_e f, input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(f, s[i]);
    end
  endtask

  // receiver: changing stall patterns, one long hold-off on request
  initial begin
    int mode;
    int left;
    int beat;
    m_axis_tready = 1'b0;
    mode = 0;
    left = 0;
    beat = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 150);
      end
      left--;
      beat++;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 99) >= 35);
        default: m_axis_tready <= (beat % 3 != 2);
      endcase
    end
  end

  // stimulus and verdict
  initial begin
    int r;
    int nterms;
    int tlen;
    int nrec;
    int npieces;
    int pick;
    bit hold_done;
    logic [7:0] b;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    sent_count    = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    pool_n        = 0;
    hold_done     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty query after reset matches any record
    send_item(mtsf_pkg::FuncEnd, 8'hFF);
    send_item(mtsf_pkg::FuncRecord, 8'h00);
    send_item(mtsf_pkg::FuncRecord, 8'hFF);
    send_item(mtsf_pkg::FuncEnd, 8'h00);
    // leading, doubled and trailing spaces give empty terms
    send_item(mtsf_pkg::FuncClear, 8'hA5);
    send_string(mtsf_pkg::FuncAppend, " ab  c ");
    send_string(mtsf_pkg::FuncRecord, "xcab");
    send_item(mtsf_pkg::FuncEnd, 8'h5A);
    send_string(mtsf_pkg::FuncRecord, "ab");
    send_item(mtsf_pkg::FuncEnd, 8'h00);
    // query changed in the middle of a record drops the partial matches
    send_item(mtsf_pkg::FuncRecord, "c");
    send_item(mtsf_pkg::FuncAppend, "d");
    send_string(mtsf_pkg::FuncRecord, "ab");
    send_item(mtsf_pkg::FuncEnd, 8'hFF);

    // random phases: a new query in most of them, then records built around its terms
    while (sent_count < ItemTarget) begin
      if ($urandom_range(0, 9) < 7) begin
        send_item(mtsf_pkg::FuncClear, 8'($urandom_range(0, 255)));
        pool_n = 0;
        r = $urandom_range(0, 99);
        nterms = (r < 75) ? $urandom_range(1, 4) :
                 (r < 90) ? $urandom_range(5, 8) : $urandom_range(9, 11);
        if ($urandom_range(0, 9) == 0) send_item(mtsf_pkg::FuncAppend, mtsf_pkg::SpaceChar);
        for (int k = 0; k < nterms; k++) begin
          if (k > 0) begin
            send_item(mtsf_pkg::FuncAppend, mtsf_pkg::SpaceChar);
            if ($urandom_range(0, 9) == 0) begin
              send_item(mtsf_pkg::FuncAppend, mtsf_pkg::SpaceChar);
            end
          end
          r = $urandom_range(0, 99);
          tlen = (r < 85) ? $urandom_range(1, 4) :
                 (r < 92) ? $urandom_range(5, 12) : $urandom_range(30, 36);
          for (int j = 0; j < tlen; j++) begin
            b = pick_char();
            pool_text[pool_n][j] = b;
            send_item(mtsf_pkg::FuncAppend, b);
          end
          pool_len[pool_n] = tlen;
          pool_n++;
        end
        if ($urandom_range(0, 9) == 0) send_item(mtsf_pkg::FuncAppend, mtsf_pkg::SpaceChar);
      end

      // once, halfway through, the receiver holds off while items keep coming
      if (!hold_done && sent_count >= ItemTarget / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end

      nrec = $urandom_range(1, 6);
      for (int n = 0; n < nrec; n++) begin
        npieces = $urandom_range(0, 5);
        for (int p = 0; p < npieces; p++) begin
          r = $urandom_range(0, 99);
          if (r < 45 && pool_n > 0) begin
            pick = $urandom_range(0, pool_n - 1);
            for (int j = 0; j < pool_len[pick]; j++) begin
              send_item(mtsf_pkg::FuncRecord, pool_text[pick][j]);
            end
          end else if (r < 50) begin
            if ($urandom_range(0, 1)) send_item(mtsf_pkg::FuncAppend, pick_char());
            else send_item(mtsf_pkg::FuncClear, 8'($urandom_range(0, 255)));
          end else begin
            repeat ($urandom_range(1, 4)) send_item(mtsf_pkg::FuncRecord, pick_char());
          end
        end
        send_item(mtsf_pkg::FuncEnd, 8'($urandom_range(0, 255)));
      end

      // noise items
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          send_item(mtsf_pkg::func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then a short quiet stretch
    while (pending_results != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
